[hdl/fvcc_pkg.sv]
// ----------------------------------------------------------------------------
// fvcc_pkg
// Types and constants shared by the flow vector color coder.
// ----------------------------------------------------------------------------
package fvcc_pkg;

  localparam int FLOW_BITS    = 16;
  localparam int MAG_W        = FLOW_BITS + 1;
  localparam int ROOT_W       = FLOW_BITS;
  localparam int SQ_W         = 2 * FLOW_BITS;
  localparam int CORDIC_ITERS = 14;
  localparam int PRESHIFT     = 8;
  localparam int XY_W         = FLOW_BITS + PRESHIFT + 3;
  localparam int Z_W          = 18;
  localparam int ANG_W        = 16;
  localparam int RAD_W        = 17;
  localparam int POS_W        = 22;
  localparam int MIX_W        = 24;
  localparam int PROD_W       = 41;
  localparam int WHEEL_N      = 55;
  localparam int WHEEL_AW     = 6;
  localparam int CNT_W        = 5;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SCAN   = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_SCAN,
    KIND_RENDER,
    KIND_BLACK
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_RANGE,
    ST_DIV,
    ST_CORDIC,
    ST_ANGLE,
    ST_MIX,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]                  op;
    logic signed [FLOW_BITS-1:0] flow_x;
    logic signed [FLOW_BITS-1:0] flow_y;
    logic                        unknown;
  } flow_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [FLOW_BITS-1:0] fx;
    logic signed [FLOW_BITS-1:0] fy;
  } cmd_t;

  localparam logic [13:0] ATAN_TURNS [CORDIC_ITERS] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
    14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
  };

  // {red, green, blue}
  localparam logic [23:0] WHEEL [WHEEL_N] = '{
    24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400,
    24'hFF5500, 24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900,
    24'hFFAA00, 24'hFFBB00, 24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
    24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00,
    24'h2BFF00,
    24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
    24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF,
    24'h008CFF, 24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF,
    24'h0018FF,
    24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF,
    24'h6200FF, 24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF,
    24'hC400FF, 24'hD700FF, 24'hEB00FF,
    24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055,
    24'hFF002B
  };

endpackage

[hdl/fvcc_front.sv]
// ----------------------------------------------------------------------------
// fvcc_front
// Accepts requests, classifies them, drops unknown scans and no-op requests, and holds the rest in a two-entry queue.
// ----------------------------------------------------------------------------
module fvcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fvcc_pkg::flow_req_t req_item,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output fvcc_pkg::cmd_t      cmd_item
);

  fvcc_pkg::cmd_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           keep;
  fvcc_pkg::cmd_t cls;
  logic           push;
  logic           pop;

  always_comb begin
    keep     = 1'b1;
    cls.fx   = req_item.flow_x;
    cls.fy   = req_item.flow_y;
    cls.kind = fvcc_pkg::KIND_START;
    unique case (fvcc_pkg::op_t'(req_item.op))
      fvcc_pkg::OP_START: cls.kind = fvcc_pkg::KIND_START;
      fvcc_pkg::OP_SCAN: begin
        cls.kind = fvcc_pkg::KIND_SCAN;
        keep     = !req_item.unknown;
      end
      fvcc_pkg::OP_RENDER: begin
        cls.kind = req_item.unknown ? fvcc_pkg::KIND_BLACK : fvcc_pkg::KIND_RENDER;
      end
      default: keep = 1'b0;
    endcase
  end

  assign req_ready = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd_item  = q[rp];
  assign push      = req_valid && req_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/fvcc_back.sv]
// ----------------------------------------------------------------------------
// fvcc_back
// Sequencer: magnitude, peak tracking, radius divide, CORDIC angle, wheel mix.
// ----------------------------------------------------------------------------
module fvcc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fvcc_pkg::cmd_t     cmd_item,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output fvcc_pkg::rgb_t     rsp_item
);

  localparam int XY_W = fvcc_pkg::XY_W;
  localparam int Z_W  = fvcc_pkg::Z_W;

  fvcc_pkg::state_t state, state_next;

  fvcc_pkg::kind_t                       kind;
  logic signed [fvcc_pkg::FLOW_BITS-1:0] fx;
  logic signed [fvcc_pkg::FLOW_BITS-1:0] fy;
  logic [fvcc_pkg::SQ_W-1:0]             sq_x;
  logic [fvcc_pkg::SQ_W-1:0]             sq_y;
  logic [fvcc_pkg::SQ_W-1:0]             num;
  logic [fvcc_pkg::SQ_W-1:0]             root;
  logic [fvcc_pkg::CNT_W-1:0]            cnt;
  logic [fvcc_pkg::ROOT_W-1:0]           mag;
  logic [fvcc_pkg::MAG_W-1:0]            peak;
  logic [fvcc_pkg::MAG_W:0]              rem;
  logic [fvcc_pkg::RAD_W-1:0]            quo;
  logic                                  in_range;
  logic                                  zero_vec;
  logic signed [XY_W-1:0]                x;
  logic signed [XY_W-1:0]                y;
  logic signed [Z_W-1:0]                 z;
  logic [fvcc_pkg::POS_W-1:0]            pos;
  logic [fvcc_pkg::MIX_W-1:0]            mix [3];
  logic [fvcc_pkg::PROD_W-1:0]           prod [3];
  logic                                  black;

  // combinational helpers
  logic [fvcc_pkg::FLOW_BITS-1:0] ax, ay;
  logic [fvcc_pkg::SQ_W-1:0]      bitv, trial, root_next;
  logic                           sq_ge;
  logic                           dv_ge;
  logic [fvcc_pkg::MAG_W:0]       rem_after;
  logic signed [XY_W-1:0]         fx_ext, fy_ext, xs, ys;
  logic [3:0]                     it;
  logic signed [Z_W-1:0]          atan_v;
  logic [fvcc_pkg::ANG_W-1:0]     ang;
  logic [fvcc_pkg::WHEEL_AW-1:0]  k0, k1;
  logic [16:0]                    f, f_inv;
  logic [23:0]                    c0, c1;
  logic [fvcc_pkg::PROD_W-1:0]    full_scale;
  fvcc_pkg::rgb_t                 color;
  logic [7:0]                     chan [3];
  logic [25:0]                    over3 [3];
  logic                           load_out;

  assign cmd_ready = (state == fvcc_pkg::ST_IDLE);

  always_comb begin
    ax        = fx[fvcc_pkg::FLOW_BITS-1] ? fvcc_pkg::FLOW_BITS'(-fx) : fvcc_pkg::FLOW_BITS'(fx);
    ay        = fy[fvcc_pkg::FLOW_BITS-1] ? fvcc_pkg::FLOW_BITS'(-fy) : fvcc_pkg::FLOW_BITS'(fy);
    bitv      = fvcc_pkg::SQ_W'(1) << {cnt[3:0], 1'b0};
    trial     = root + bitv;
    sq_ge     = (num >= trial);
    root_next = sq_ge ? ((root >> 1) + bitv) : (root >> 1);
    dv_ge     = (rem >= (fvcc_pkg::MAG_W + 1)'(peak));
    rem_after = dv_ge ? (rem - (fvcc_pkg::MAG_W + 1)'(peak)) : rem;
    fx_ext    = XY_W'(fx) <<< fvcc_pkg::PRESHIFT;
    fy_ext    = XY_W'(fy) <<< fvcc_pkg::PRESHIFT;
    it        = cnt[3:0];
    xs        = x >>> it;
    ys        = y >>> it;
    atan_v    = $signed({4'b0, fvcc_pkg::ATAN_TURNS[it]});
    ang       = zero_vec ? '0 : z[fvcc_pkg::ANG_W-1:0];
    k0        = pos[fvcc_pkg::POS_W-1:16];
    k1        = (k0 == 6'(fvcc_pkg::WHEEL_N - 1)) ? '0 : k0 + 6'd1;
    f         = {1'b0, pos[15:0]};
    f_inv     = 17'h10000 - f;
    c0        = fvcc_pkg::WHEEL[k0];
    c1        = fvcc_pkg::WHEEL[k1];
    full_scale = fvcc_pkg::PROD_W'(255) << 32;
    for (int ch = 0; ch < 3; ch++) begin
      over3[ch] = 26'(mix[ch]) * 26'd3;
      if (in_range) begin
        chan[ch] = 8'((full_scale - prod[ch]) >> 32);
      end else begin
        chan[ch] = over3[ch][25:18];
      end
    end
    if (black) begin
      color = '0;
    end else begin
      color.red   = chan[0];
      color.green = chan[1];
      color.blue  = chan[2];
    end
    load_out = (state == fvcc_pkg::ST_OUT) && (!rsp_valid || rsp_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fvcc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_item.kind)
            fvcc_pkg::KIND_START:  state_next = fvcc_pkg::ST_IDLE;
            fvcc_pkg::KIND_BLACK:  state_next = fvcc_pkg::ST_OUT;
            default:               state_next = fvcc_pkg::ST_SQUARE;
          endcase
        end
      end
      fvcc_pkg::ST_SQUARE: state_next = fvcc_pkg::ST_SUM;
      fvcc_pkg::ST_SUM:    state_next = fvcc_pkg::ST_SQRT;
      fvcc_pkg::ST_SQRT: begin
        if (cnt == '0) begin
          state_next = (kind == fvcc_pkg::KIND_SCAN) ? fvcc_pkg::ST_IDLE : fvcc_pkg::ST_RANGE;
        end
      end
      fvcc_pkg::ST_RANGE: begin
        if (peak == '0 || fvcc_pkg::MAG_W'(mag) > peak) begin
          state_next = fvcc_pkg::ST_CORDIC;
        end else begin
          state_next = fvcc_pkg::ST_DIV;
        end
      end
      fvcc_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = fvcc_pkg::ST_CORDIC;
        end
      end
      fvcc_pkg::ST_CORDIC: begin
        if (cnt == 5'(fvcc_pkg::CORDIC_ITERS - 1)) begin
          state_next = fvcc_pkg::ST_ANGLE;
        end
      end
      fvcc_pkg::ST_ANGLE: state_next = fvcc_pkg::ST_MIX;
      fvcc_pkg::ST_MIX:   state_next = fvcc_pkg::ST_SCALE;
      fvcc_pkg::ST_SCALE: state_next = fvcc_pkg::ST_OUT;
      fvcc_pkg::ST_OUT: begin
        if (load_out) begin
          state_next = fvcc_pkg::ST_IDLE;
        end
      end
      default: state_next = fvcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fvcc_pkg::ST_IDLE;
      peak      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fvcc_pkg::ST_IDLE && cmd_valid && cmd_item.kind == fvcc_pkg::KIND_START) begin
        peak <= '0;
      end
      if (state == fvcc_pkg::ST_SQRT && cnt == '0 && kind == fvcc_pkg::KIND_SCAN &&
          fvcc_pkg::MAG_W'(root_next) > peak) begin
        peak <= fvcc_pkg::MAG_W'(root_next);
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // cordic start values, shared by range and divide exits
  logic signed [XY_W-1:0] cx0, cy0;
  logic signed [Z_W-1:0]  cz0;
  always_comb begin
    cx0 = fx[fvcc_pkg::FLOW_BITS-1] ? -fx_ext : fx_ext;
    cy0 = fx[fvcc_pkg::FLOW_BITS-1] ? -fy_ext : fy_ext;
    cz0 = fx[fvcc_pkg::FLOW_BITS-1] ? Z_W'(32768) : '0;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fvcc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          kind  <= cmd_item.kind;
          fx    <= cmd_item.fx;
          fy    <= cmd_item.fy;
          black <= (cmd_item.kind == fvcc_pkg::KIND_BLACK);
        end
      end
      fvcc_pkg::ST_SQUARE: begin
        sq_x <= fvcc_pkg::SQ_W'(ax) * fvcc_pkg::SQ_W'(ax);
        sq_y <= fvcc_pkg::SQ_W'(ay) * fvcc_pkg::SQ_W'(ay);
      end
      fvcc_pkg::ST_SUM: begin
        num  <= sq_x + sq_y;
        root <= '0;
        cnt  <= 5'(fvcc_pkg::ROOT_W - 1);
      end
      fvcc_pkg::ST_SQRT: begin
        if (sq_ge) begin
          num <= num - trial;
        end
        root <= root_next;
        cnt  <= cnt - 5'd1;
        mag  <= fvcc_pkg::ROOT_W'(root_next);
      end
      fvcc_pkg::ST_RANGE: begin
        quo      <= '0;
        rem      <= (fvcc_pkg::MAG_W + 1)'(mag);
        zero_vec <= (fx == '0) && (fy == '0);
        if (peak == '0 || fvcc_pkg::MAG_W'(mag) > peak) begin
          in_range <= (peak == '0);
          cnt      <= '0;
          x        <= cx0;
          y        <= cy0;
          z        <= cz0;
        end else begin
          in_range <= 1'b1;
          cnt      <= 5'(fvcc_pkg::RAD_W - 1);
        end
      end
      fvcc_pkg::ST_DIV: begin
        quo <= {quo[fvcc_pkg::RAD_W-2:0], dv_ge};
        rem <= rem_after << 1;
        if (cnt == '0) begin
          cnt <= '0;
          x   <= cx0;
          y   <= cy0;
          z   <= cz0;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      fvcc_pkg::ST_CORDIC: begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_v;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_v;
        end
        cnt <= cnt + 5'd1;
      end
      fvcc_pkg::ST_ANGLE: begin
        pos <= fvcc_pkg::POS_W'(ang) * fvcc_pkg::POS_W'(54);
      end
      fvcc_pkg::ST_MIX: begin
        for (int ch = 0; ch < 3; ch++) begin
          mix[ch] <= 24'(25'(c0[23-8*ch -: 8]) * 25'(f_inv) + 25'(c1[23-8*ch -: 8]) * 25'(f));
        end
      end
      fvcc_pkg::ST_SCALE: begin
        for (int ch = 0; ch < 3; ch++) begin
          prod[ch] <= fvcc_pkg::PROD_W'(quo) * fvcc_pkg::PROD_W'(24'hFF0000 - mix[ch]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_item <= color;
    end
  end

endmodule

[hdl/flow_vector_color_coder_core.sv]
// The back sequencer takes one item at a time: a scan runs the 16-step square root, a render
// adds the 14-step CORDIC and, for a nonzero peak with the magnitude not above it, the
// 17-step radius divide; an unknown render outputs black. Two requests queue in front.
// Reset (rst, synchronous): clears the queue, the sequencer and the peak magnitude.
// ----------------------------------------------------------------------------
// flow_vector_color_coder_core
// Optical flow to RGB color wheel coder, front queue plus back sequencer.
// ----------------------------------------------------------------------------
module flow_vector_color_coder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fvcc_pkg::flow_req_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fvcc_pkg::rgb_t      rsp_item
);

  logic           cmd_valid;
  logic           cmd_ready;
  fvcc_pkg::cmd_t cmd_item;

  fvcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item)
  );

  fvcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives flow vectors through start, scan, render and no-op requests, predicts
// each color in a scoreboard and compares every response field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1030;

  class color_scoreboard;
    logic [fvcc_pkg::MAG_W-1:0] peak;
    fvcc_pkg::rgb_t             pending[$];
    int                         errors;

    function new();
      peak = '0;
      errors = 0;
    endfunction

    static function longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    static function int unsigned wheel_ch(int unsigned k, int ch);
      int unsigned r;
      int unsigned g;
      int unsigned b;
      if (k < 15) begin
        r = 255; g = 255 * k / 15; b = 0;
      end else if (k < 21) begin
        k -= 15; r = 255 - 255 * k / 6; g = 255; b = 0;
      end else if (k < 25) begin
        k -= 21; r = 0; g = 255; b = 255 * k / 4;
      end else if (k < 36) begin
        k -= 25; r = 0; g = 255 - 255 * k / 11; b = 255;
      end else if (k < 49) begin
        k -= 36; r = 255 * k / 13; g = 0; b = 255;
      end else begin
        k = (k - 49) % 6; r = 255; g = 0; b = 255 - 255 * k / 6;
      end
      return ch == 0 ? r : (ch == 1 ? g : b);
    endfunction

    static function int unsigned angle_of(longint fx, longint fy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      int     atab[fvcc_pkg::CORDIC_ITERS];
      atab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      if (fx == 0 && fy == 0) return 0;
      x = fx * 256;
      y = fy * 256;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 32768;
      end
      for (int i = 0; i < fvcc_pkg::CORDIC_ITERS; i++) begin
        xs = asr(x, i);
        ys = asr(y, i);
        if (y > 0) begin
          x = x + ys; y = y - xs; z += atab[i];
        end else begin
          x = x - ys; y = y + xs; z -= atab[i];
        end
      end
      return int'(z & 64'hFFFF);
    endfunction

    function void note_request(fvcc_pkg::flow_req_t q);
      longint          fx;
      longint          fy;
      longint unsigned mag;
      longint unsigned r;
      longint unsigned pos;
      longint unsigned f;
      longint unsigned c;
      longint unsigned v;
      int unsigned     k0;
      int unsigned     k1;
      bit              in_range;
      logic [7:0]      chan[3];
      fvcc_pkg::rgb_t  col;
      fx = q.flow_x;
      fy = q.flow_y;
      mag = isqrt(fx * fx + fy * fy);
      case (fvcc_pkg::op_t'(q.op))
        fvcc_pkg::OP_START: peak = '0;
        fvcc_pkg::OP_SCAN: if (!q.unknown && mag > peak) peak = mag[fvcc_pkg::MAG_W-1:0];
        fvcc_pkg::OP_RENDER: begin
          if (q.unknown) begin
            col = '0;
          end else begin
            if (peak == 0) begin
              r = 0; in_range = 1;
            end else if (mag > peak) begin
              r = 0; in_range = 0;
            end else begin
              r = (mag << 16) / peak; in_range = 1;
            end
            pos = longint'(angle_of(fx, fy)) * 54;
            k0 = int'(pos >> 16);
            k1 = (k0 + 1) % 55;
            f = pos & 64'hFFFF;
            for (int ch = 0; ch < 3; ch++) begin
              c = wheel_ch(k0, ch) * (65536 - f) + wheel_ch(k1, ch) * f;
              if (in_range) v = ((64'd255 << 32) - r * (64'd255 * 65536 - c)) >> 32;
              else v = (3 * c) >> 18;
              chan[ch] = v[7:0];
            end
            col = '{red: chan[0], green: chan[1], blue: chan[2]};
          end
          pending.insert(pending.size(), col);
        end
        default: ;
      endcase
    endfunction

    function void check_color(fvcc_pkg::rgb_t got);
      fvcc_pkg::rgb_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t unexpected color %h", $time, got);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.red !== exp_c.red) begin
        $display("%0t red exp %h got %h", $time, exp_c.red, got.red);
        errors++;
      end
      if (got.green !== exp_c.green) begin
        $display("%0t green exp %h got %h", $time, exp_c.green, got.green);
        errors++;
      end
      if (got.blue !== exp_c.blue) begin
        $display("%0t blue exp %h got %h", $time, exp_c.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                req_valid = 0;
  logic                req_ready;
  fvcc_pkg::flow_req_t req_item = '0;
  logic                rsp_valid;
  logic                rsp_ready = 0;
  fvcc_pkg::rgb_t      rsp_item;

  color_scoreboard sb = new();
  bit  calm = 0;
  bit  hold_off = 0;

  flow_vector_color_coder_core u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) sb.note_request(req_item);
    if (!rst && rsp_valid && rsp_ready) sb.check_color(rsp_item);
  end

  always @(negedge clk) begin
    if (rst || hold_off) rsp_ready <= 0;
    else rsp_ready <= calm || $urandom_range(99) >= 29;
  end

  task automatic send(input fvcc_pkg::op_t op, input logic signed [15:0] fx,
                      input logic signed [15:0] fy, input logic unk);
    while (!calm && $urandom_range(99) < 29) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req_item <= '{op: op, flow_x: fx, flow_y: fy, unknown: unk};
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rand(input fvcc_pkg::op_t op);
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    fx = 16'($urandom);
    fy = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      fx = $signed(fx) >>> $urandom_range(15);
      fy = $signed(fy) >>> $urandom_range(15);
    end
    send(op, fx, fy, $urandom_range(9) == 0);
  endtask

  task automatic settle();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    int n;
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send(fvcc_pkg::OP_RENDER, 16'sd100, 16'sd0, 0);
    send(fvcc_pkg::OP_SCAN, 16'sd100, 16'sd0, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd0, 16'sd0, 0);
    send(fvcc_pkg::OP_RENDER, -16'sd100, 16'sd0, 0);
    send(fvcc_pkg::OP_SCAN, 16'sh7FFF, -16'sh8000, 1);
    send(fvcc_pkg::OP_RENDER, 16'sd0, 16'sd50, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd0, -16'sd100, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd70, 16'sd70, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd300, 16'sd0, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd1, 16'sd1, 1);
    send(fvcc_pkg::OP_NONE, 16'sd5, 16'sd5, 0);
    send(fvcc_pkg::OP_SCAN, -16'sh8000, -16'sh8000, 0);
    send(fvcc_pkg::OP_RENDER, -16'sh8000, -16'sh8000, 0);
    send(fvcc_pkg::OP_RENDER, 16'sh7FFF, 16'sh7FFF, 0);
    send(fvcc_pkg::OP_RENDER, 16'sh7FFF, -16'sh8000, 0);
    send(fvcc_pkg::OP_RENDER, -16'sd1, 16'sd0, 0);
    send(fvcc_pkg::OP_START, 16'sd0, 16'sd0, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd3, -16'sd4, 0);
    send(fvcc_pkg::OP_SCAN, -16'sd1, -16'sd1, 0);
    send(fvcc_pkg::OP_RENDER, 16'sd1, -16'sd1, 0);
    settle();
    // receiver stalls while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send_rand(fvcc_pkg::OP_RENDER);
    join
    n = 0;
    while (n < N_RANDOM) begin
      calm = (n >= 400 && n < 550);
      k = $urandom_range(99);
      if (k < 85) begin
        send(fvcc_pkg::OP_START, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        n++;
        repeat ($urandom_range(6, 1)) begin
          send_rand(fvcc_pkg::OP_SCAN); n++;
        end
        repeat ($urandom_range(10, 1)) begin
          send_rand(fvcc_pkg::OP_RENDER); n++;
        end
      end else begin
        send_rand(fvcc_pkg::op_t'($urandom_range(3)));
        n++;
      end
    end
    calm = 0;
    req_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
